// ===== rtl/core/ccam_pkg.sv =====
`default_nettype none
package ccam_pkg;

    localparam int LETTERS = 52;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    localparam logic REG_SUFFIX_MODE = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_OPEN = 4'b0010,
        PH_SET  = 4'b0100,
        PH_NEG  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                neg;
        logic [LETTERS-1:0]  mask;
    } class_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    // one-hot letter position: A-Z at 0..25, a-z at 26..51
    function automatic logic [LETTERS-1:0] letter_bit(input logic [7:0] b);
        logic [LETTERS-1:0] r;
        r = '0;
        if ((b >= 8'h41) && (b <= 8'h5A)) begin
            r[6'(b - 8'h41)] = 1'b1;
        end else if ((b >= 8'h61) && (b <= 8'h7A)) begin
            r[6'(b - 8'h47)] = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/char_class_affix_matcher_core.sv =====
// Character-class affix matcher.
// Input stream (s_*): one byte per word. s_tuser[0] = 0 for a pattern byte, 1 for
// a word byte; s_tdata is the byte; s_tlast closes the pattern or the word.
// Pattern bytes build up to MAX_POS positions (letters, [set], [^set]); the
// final pattern byte yields a compile-status word. The final word byte yields
// a verdict: prefix match, or suffix match when suffix_mode is set over APB
// (byte address 0, bit 0).
// Result stream (m_*): m_tuser[0] = verdict kind; m_tdata = {position_total,
// status, matched}. One output register holds the result until taken.
// Sequencing: a pattern byte is handled as it is accepted. A word byte goes
// through a class memory read, then a compare in the shared class unit. The
// last word byte in suffix mode then has the shared unit walk the class memory
// over each compiled position before the verdict is written.
// s_tready is low while an item is in progress and while a result waits and
// m_tready is low; the block stalls until the output register is free.
// Reset (aresetn, synchronous) leaves no valid pattern, an empty word and
// prefix mode.
`default_nettype none
module char_class_affix_matcher_core #(
    parameter int MAX_POS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [0:0]  s_tuser,   // [0] kind
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [0] matched, [2:1] status, [7:3] position_total
    output logic      [0:0]  m_tuser,   // [0] verdict_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW = (MAX_POS > 1) ? $clog2(MAX_POS) : 1;
    localparam int CW = $clog2(MAX_POS + 1);

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_CHK  = 3'b010,
        SQ_WALK = 3'b100
    } seq_t;

    seq_t                state_reg, state_next;
    ccam_pkg::phase_t    phase_reg, phase_next;
    ccam_pkg::status_t   status_reg, status_next;
    ccam_pkg::class_t    cur_class_reg, cur_class_next;
    logic                open_reg, open_next;
    logic [CW-1:0]       pc_reg, pc_next;
    logic [CW-1:0]       wc_reg, wc_next;
    logic [CW-1:0]       walk_reg, walk_next;
    logic                prefix_ok_reg, prefix_ok_next;
    logic                walk_ok_reg, walk_ok_next;
    logic                chk_en_reg, chk_en_next;
    logic                last_reg, last_next;
    logic                suffix_mode_reg, suffix_mode_next;
    logic [7:0]          sym_reg, sym_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_kind_reg, m_kind_next;
    logic [7:0]          m_data_reg, m_data_next;
    logic [7:0]          tail_reg [MAX_POS];

    logic                s_acc;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    ccam_pkg::class_t    ram_wdata;
    ccam_pkg::class_t    ram_rdata;
    logic [7:0]          unit_sym;
    logic                unit_hit;
    logic [CW-1:0]       tidx;

    assign s_tready = (state_reg == SQ_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ccam_pkg::REG_SUFFIX_MODE) ? {31'b0, suffix_mode_reg} : '0;
    assign tidx     = CW'(MAX_POS) - pc_reg + walk_reg;

    ccam_ram #(
        .WIDTH ($bits(ccam_pkg::class_t)),
        .DEPTH (MAX_POS)
    ) u_class_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ccam_class_unit u_class_unit (
        .cls (ram_rdata),
        .sym (unit_sym),
        .hit (unit_hit)
    );

    always_comb begin
        logic [CW-1:0]     eff_pc;
        ccam_pkg::phase_t  eff_phase;
        ccam_pkg::status_t eff_status;
        ccam_pkg::class_t  new_class;
        logic [AW-1:0]     cur_addr;
        logic              pok;
        logic              res_valid;
        logic              res_long;
        logic              ok;
        logic [1:0]        vstat;

        state_next       = state_reg;
        phase_next       = phase_reg;
        status_next      = status_reg;
        cur_class_next   = cur_class_reg;
        open_next        = open_reg;
        pc_next          = pc_reg;
        wc_next          = wc_reg;
        walk_next        = walk_reg;
        prefix_ok_next   = prefix_ok_reg;
        walk_ok_next     = walk_ok_reg;
        chk_en_next      = chk_en_reg;
        last_next        = last_reg;
        suffix_mode_next = suffix_mode_reg;
        sym_next         = sym_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_kind_next      = m_kind_reg;
        m_data_next      = m_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = cur_class_reg;
        ram_raddr        = wc_reg[AW-1:0];
        unit_sym         = sym_reg;
        eff_pc           = open_reg ? pc_reg : '0;
        eff_phase        = open_reg ? phase_reg : ccam_pkg::PH_WAIT;
        eff_status       = open_reg ? status_reg : ccam_pkg::ST_NONE;
        new_class        = cur_class_reg;
        cur_addr         = AW'(eff_pc - 1'b1);
        pok              = prefix_ok_reg && !(chk_en_reg && !unit_hit);
        res_valid        = !open_reg && (status_reg == ccam_pkg::ST_OK);
        res_long         = wc_reg >= pc_reg;
        ok               = walk_ok_reg && unit_hit;
        vstat            = res_valid ? ccam_pkg::ST_OK : ccam_pkg::ST_NONE;

        if (psel && penable && pwrite && (paddr[2] == ccam_pkg::REG_SUFFIX_MODE)) begin
            suffix_mode_next = pwdata[0];
        end

        unique case (state_reg)
            SQ_IDLE: begin
                if (s_acc && !s_tuser[0]) begin
                    if (eff_status == ccam_pkg::ST_NONE) begin
                        unique case (eff_phase)
                            ccam_pkg::PH_WAIT: begin
                                if (ccam_pkg::is_letter(s_tdata) ||
                                    (s_tdata == ccam_pkg::CH_LBRACK)) begin
                                    if (eff_pc >= CW'(MAX_POS)) begin
                                        eff_status = ccam_pkg::ST_OVERFLOW;
                                    end else begin
                                        new_class      = '0;
                                        new_class.mask = ccam_pkg::letter_bit(s_tdata);
                                        if (!ccam_pkg::is_letter(s_tdata)) begin
                                            eff_phase = ccam_pkg::PH_OPEN;
                                        end
                                        ram_we    = 1'b1;
                                        ram_waddr = AW'(eff_pc);
                                        eff_pc    = eff_pc + 1'b1;
                                    end
                                end else begin
                                    eff_status = ccam_pkg::ST_SYNTAX;
                                end
                            end
                            ccam_pkg::PH_OPEN: begin
                                if (s_tdata == ccam_pkg::CH_CARET) begin
                                    new_class.neg = 1'b1;
                                    eff_phase     = ccam_pkg::PH_NEG;
                                    ram_we        = 1'b1;
                                    ram_waddr     = cur_addr;
                                end else if (ccam_pkg::is_letter(s_tdata)) begin
                                    new_class.mask = new_class.mask |
                                                     ccam_pkg::letter_bit(s_tdata);
                                    eff_phase      = ccam_pkg::PH_SET;
                                    ram_we         = 1'b1;
                                    ram_waddr      = cur_addr;
                                end else begin
                                    eff_status = ccam_pkg::ST_SYNTAX;
                                end
                            end
                            default: begin
                                if (ccam_pkg::is_letter(s_tdata)) begin
                                    new_class.mask = new_class.mask |
                                                     ccam_pkg::letter_bit(s_tdata);
                                    ram_we         = 1'b1;
                                    ram_waddr      = cur_addr;
                                end else if (s_tdata == ccam_pkg::CH_RBRACK) begin
                                    eff_phase = ccam_pkg::PH_WAIT;
                                end else begin
                                    eff_status = ccam_pkg::ST_SYNTAX;
                                end
                            end
                        endcase
                    end
                    ram_wdata      = new_class;
                    cur_class_next = new_class;
                    if (s_tlast) begin
                        open_next = 1'b0;
                        if (eff_status == ccam_pkg::ST_NONE) begin
                            eff_status = ccam_pkg::ST_OK;
                        end
                        m_valid_next = 1'b1;
                        m_kind_next  = 1'b0;
                        m_data_next  = {5'(eff_pc), eff_status, 1'b0};
                    end else begin
                        open_next = 1'b1;
                    end
                    pc_next     = eff_pc;
                    phase_next  = eff_phase;
                    status_next = eff_status;
                end else if (s_acc) begin
                    sym_next    = s_tdata;
                    last_next   = s_tlast;
                    chk_en_next = wc_reg < pc_reg;
                    if (wc_reg < CW'(MAX_POS)) begin
                        wc_next = wc_reg + 1'b1;
                    end
                    state_next = SQ_CHK;
                end
            end
            SQ_CHK: begin
                prefix_ok_next = pok;
                ram_raddr      = '0;
                state_next     = SQ_IDLE;
                if (last_reg) begin
                    if (res_valid && res_long && suffix_mode_reg && (pc_reg != '0)) begin
                        state_next   = SQ_WALK;
                        walk_next    = '0;
                        walk_ok_next = 1'b1;
                    end else begin
                        m_valid_next   = 1'b1;
                        m_kind_next    = 1'b1;
                        m_data_next    = {5'(pc_reg), vstat,
                                          res_valid && res_long && (suffix_mode_reg || pok)};
                        wc_next        = '0;
                        prefix_ok_next = 1'b1;
                    end
                end
            end
            SQ_WALK: begin
                unit_sym     = tail_reg[tidx[AW-1:0]];
                walk_ok_next = ok;
                walk_next    = walk_reg + 1'b1;
                ram_raddr    = AW'(walk_reg + 1'b1);
                if ((walk_reg + 1'b1) == pc_reg) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = 1'b1;
                    m_data_next    = {5'(pc_reg), ccam_pkg::ST_OK, ok};
                    wc_next        = '0;
                    prefix_ok_next = 1'b1;
                    state_next     = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SQ_IDLE;
            phase_reg       <= ccam_pkg::PH_WAIT;
            status_reg      <= ccam_pkg::ST_NONE;
            open_reg        <= 1'b0;
            pc_reg          <= '0;
            wc_reg          <= '0;
            walk_reg        <= '0;
            prefix_ok_reg   <= 1'b1;
            walk_ok_reg     <= 1'b1;
            chk_en_reg      <= 1'b0;
            last_reg        <= 1'b0;
            suffix_mode_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            status_reg      <= status_next;
            open_reg        <= open_next;
            pc_reg          <= pc_next;
            wc_reg          <= wc_next;
            walk_reg        <= walk_next;
            prefix_ok_reg   <= prefix_ok_next;
            walk_ok_reg     <= walk_ok_next;
            chk_en_reg      <= chk_en_next;
            last_reg        <= last_next;
            suffix_mode_reg <= suffix_mode_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_class_reg <= cur_class_next;
        sym_reg       <= sym_next;
        m_kind_reg    <= m_kind_next;
        m_data_reg    <= m_data_next;
        if (s_acc && s_tuser[0]) begin
            for (int i = 0; i < MAX_POS - 1; i++) begin
                tail_reg[i] <= tail_reg[i+1];
            end
            tail_reg[MAX_POS-1] <= s_tdata;
        end
    end

    a_pc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= CW'(MAX_POS))
        else $error("position count beyond MAX_POS");

    a_pattern_unmatched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> !m_tdata[0])
        else $error("pattern status word flagged as matched");

    a_match_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] && m_tdata[0]) |-> (m_tdata[2:1] == ccam_pkg::ST_OK))
        else $error("match reported without a valid pattern");

    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_WALK) |-> (walk_reg < pc_reg))
        else $error("suffix walk past last position");

    a_walk_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_WALK) |-> (suffix_mode_reg && (status_reg == ccam_pkg::ST_OK)))
        else $error("suffix walk without suffix mode or valid pattern");

endmodule
`default_nettype wire

// ===== rtl/core/ccam_ram.sv =====
`default_nettype none
module ccam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ccam_class_unit.sv =====
`default_nettype none
module ccam_class_unit (
    input  wire ccam_pkg::class_t cls,
    input  wire logic [7:0]       sym,
    output logic                  hit
);
    // zero and non-letters are never members; negation flips
    assign hit = (|(cls.mask & ccam_pkg::letter_bit(sym))) ^ cls.neg;
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccam_pkg::*;

    localparam int MAX_POS     = 16;
    localparam int PERIOD      = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;

    localparam logic [2:0] SUFFIX_ADDR = 3'(4 * int'(REG_SUFFIX_MODE));

    typedef enum int {PAT_CLEAN, PAT_CORRUPT, PAT_CUT} pat_shape_t;

    typedef struct packed {
        logic       kind;
        logic       matched;
        status_t    status;
        logic [4:0] total;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] symbol
    logic [0:0]  s_tuser;   // [0] kind
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] matched, [2:1] status, [7:3] position_total
    logic [0:0]  m_tuser;   // [0] verdict_kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    char_class_affix_matcher_core #(
        .MAX_POS(MAX_POS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // matcher state as the testbench sees it
    logic [255:0] set_mask [MAX_POS];
    logic         set_neg  [MAX_POS];
    phase_t       parse_at;
    int unsigned  n_pos;
    status_t      pat_state;
    bit           pat_open;
    int unsigned  word_len;
    bit           head_ok;
    logic [7:0]   tail [MAX_POS];
    bit           suffix_cfg;

    verdict_t     expected_verdicts[$];
    int           mismatches;
    int           sent_items;
    int           quiet_cycles;
    int           hold_request;
    bit           rst_done;
    bit           sender_idle_on;
    bit           receiver_idle_on;
    logic [7:0]   pat_bytes[$];
    logic [7:0]   word_bytes[$];

    function automatic void clear_model();
        int i;
        for (i = 0; i < MAX_POS; i++) begin
            set_mask[i] = '0;
            set_neg[i]  = 1'b0;
            tail[i]     = 8'h00;
        end
        parse_at   = PH_WAIT;
        n_pos      = 0;
        pat_state  = ST_NONE;
        pat_open   = 1'b0;
        word_len   = 0;
        head_ok    = 1'b1;
        suffix_cfg = 1'b0;
    endfunction

    function automatic bit letter_byte(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        return (folded >= 8'h61) && (folded <= 8'h7A);
    endfunction

    function automatic bit admits(input int unsigned pos, input logic [7:0] b);
        return set_mask[pos][b] ^ set_neg[pos];
    endfunction

    function automatic bit open_position();
        if (n_pos >= MAX_POS) begin
            pat_state = ST_OVERFLOW;
            return 1'b0;
        end
        set_mask[n_pos] = '0;
        set_neg[n_pos]  = 1'b0;
        n_pos++;
        return 1'b1;
    endfunction

    function automatic void absorb_pattern_byte(input logic [7:0] b);
        int unsigned cur;
        if (pat_state != ST_NONE)
            return;
        cur = (n_pos - 1) % MAX_POS;
        case (parse_at)
            PH_WAIT: begin
                if (letter_byte(b)) begin
                    if (open_position())
                        set_mask[n_pos - 1][b] = 1'b1;
                end else if (b == CH_LBRACK) begin
                    if (open_position())
                        parse_at = PH_OPEN;
                end else begin
                    pat_state = ST_SYNTAX;
                end
            end
            PH_OPEN: begin
                if (b == CH_CARET) begin
                    set_neg[cur] = 1'b1;
                    parse_at = PH_NEG;
                end else if (letter_byte(b)) begin
                    set_mask[cur][b] = 1'b1;
                    parse_at = PH_SET;
                end else begin
                    pat_state = ST_SYNTAX;
                end
            end
            default: begin
                if (letter_byte(b))
                    set_mask[cur][b] = 1'b1;
                else if (b == CH_RBRACK)
                    parse_at = PH_WAIT;
                else
                    pat_state = ST_SYNTAX;
            end
        endcase
    endfunction

    function automatic void predict_verdict(input logic kind, input logic [7:0] b,
                                            input logic last, output bit has,
                                            output verdict_t v);
        bit valid;
        bit ok;
        int j;
        has = 1'b0;
        v   = '0;
        if (!kind) begin
            if (!pat_open) begin
                pat_open  = 1'b1;
                n_pos     = 0;
                parse_at  = PH_WAIT;
                pat_state = ST_NONE;
            end
            absorb_pattern_byte(b);
            if (!last)
                return;
            pat_open = 1'b0;
            if (pat_state == ST_NONE)
                pat_state = ST_OK;
            has       = 1'b1;
            v.kind    = 1'b0;
            v.matched = 1'b0;
            v.status  = pat_state;
            v.total   = 5'(n_pos);
            return;
        end
        if (word_len < n_pos && !admits(word_len, b))
            head_ok = 1'b0;
        for (j = 0; j < MAX_POS - 1; j++)
            tail[j] = tail[j + 1];
        tail[MAX_POS - 1] = b;
        if (word_len < MAX_POS)
            word_len++;
        if (!last)
            return;
        valid = !pat_open && pat_state == ST_OK;
        ok    = 1'b0;
        if (valid && word_len >= n_pos) begin
            if (suffix_cfg) begin
                ok = 1'b1;
                for (j = 0; j < int'(n_pos); j++)
                    if (!admits(j, tail[MAX_POS - n_pos + j]))
                        ok = 1'b0;
            end else begin
                ok = head_ok;
            end
        end
        has       = 1'b1;
        v.kind    = 1'b1;
        v.matched = ok;
        v.status  = valid ? ST_OK : ST_NONE;
        v.total   = 5'(n_pos);
        word_len  = 0;
        head_ok   = 1'b1;
        for (j = 0; j < MAX_POS; j++)
            tail[j] = 8'h00;
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] rand_symbol();
        return $urandom_range(0, 1) ? rand_letter() : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] fit_byte(input int pos);
        logic [7:0] fits[$];
        int c;
        for (c = 0; c < 256; c++)
            if (admits(pos, 8'(c)))
                fits.push_back(8'(c));
        if (fits.size() == 0)
            return rand_symbol();
        return fits[$urandom_range(0, fits.size() - 1)];
    endfunction

    function automatic int pick_positions();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 4);
        if (r < 19)
            return $urandom_range(5, MAX_POS);
        return $urandom_range(MAX_POS + 1, MAX_POS + 2);
    endfunction

    function automatic pat_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 19);
        if (r < 17)
            return PAT_CLEAN;
        if (r < 19)
            return PAT_CORRUPT;
        return PAT_CUT;
    endfunction

    function automatic void build_pattern(input int n_sets, input pat_shape_t shape);
        int i;
        int r;
        int cut;
        pat_bytes.delete();
        for (i = 0; i < n_sets; i++) begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                pat_bytes.push_back(rand_letter());
            end else begin
                pat_bytes.push_back(CH_LBRACK);
                if (r == 2)
                    pat_bytes.push_back(CH_CARET);
                repeat ($urandom_range(1, 4)) pat_bytes.push_back(rand_letter());
                pat_bytes.push_back(CH_RBRACK);
            end
        end
        if (shape == PAT_CORRUPT) begin
            pat_bytes[$urandom_range(0, pat_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (shape == PAT_CUT) begin
            cut = $urandom_range(1, pat_bytes.size());
            while (pat_bytes.size() > cut)
                void'(pat_bytes.pop_back());
        end
    endfunction

    function automatic void build_word();
        int r;
        int j;
        int lead;
        int trail;
        word_bytes.delete();
        r = $urandom_range(0, 9);
        if (r >= 8 || n_pos == 0) begin
            repeat ($urandom_range(1, 24)) word_bytes.push_back(rand_symbol());
            return;
        end
        if (r == 7 && n_pos > 1) begin
            repeat ($urandom_range(1, n_pos - 1)) word_bytes.push_back(rand_symbol());
            return;
        end
        lead  = suffix_cfg ? $urandom_range(0, 4) : 0;
        trail = suffix_cfg ? 0 : $urandom_range(0, 4);
        repeat (lead) word_bytes.push_back(rand_symbol());
        for (j = 0; j < int'(n_pos); j++)
            word_bytes.push_back(($urandom_range(0, 9) == 0) ? rand_symbol() : fit_byte(j));
        repeat (trail) word_bytes.push_back(rand_symbol());
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] sym, input logic last);
        int gap;
        bit has;
        verdict_t v;
        gap = sender_idle_on ? $urandom_range(0, 17) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= sym;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_verdict(kind, sym, last, has, v);
        if (has)
            expected_verdicts.push_back(v);
        sent_items++;
    endtask

    task automatic send_bytes(input logic kind, input logic [7:0] q[$], input bit close);
        int i;
        for (i = 0; i < q.size(); i++)
            send_item(kind, q[i], close && (i == q.size() - 1));
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_reg(input logic [2:0] addr, output logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_suffix_mode(input bit mode);
        logic [31:0] back;
        quiesce();
        write_reg(SUFFIX_ADDR, 32'(mode));
        suffix_cfg = mode;
        read_reg(SUFFIX_ADDR, back);
        if (back !== 32'(mode)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("suffix_mode readback: expected %0d, got %0h", mode, back);
        end
    endtask

    task automatic test_unpatterned_word();
        send_item(1'b1, "a", 1'b1);
    endtask

    task automatic test_bad_patterns();
        send_item(1'b0, 8'h00, 1'b1);
        send_item(1'b0, 8'hFF, 1'b1);
    endtask

    // open-ended sets: [^ takes any byte, [ takes none
    task automatic test_unclosed_sets();
        send_item(1'b0, CH_LBRACK, 1'b0);
        send_item(1'b0, CH_CARET, 1'b1);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b0, CH_LBRACK, 1'b1);
        send_item(1'b1, 8'hFF, 1'b1);
    endtask

    task automatic test_overflow();
        int i;
        pat_bytes.delete();
        for (i = 0; i <= MAX_POS; i++)
            pat_bytes.push_back(i[0] ? 8'(8'h7A - i) : 8'(8'h5A - i));
        send_bytes(1'b0, pat_bytes, 1'b1);
        send_item(1'b1, "A", 1'b1);
    endtask

    task automatic test_interleave();
        send_item(1'b1, "q", 1'b0);
        send_item(1'b0, "b", 1'b1);
        send_item(1'b1, "x", 1'b1);
    endtask

    task automatic test_random_traffic(input int items);
        int target;
        int r;
        int k;
        int i;
        target = sent_items + items;
        while (sent_items < target) begin
            if ($urandom_range(0, 63) == 0)
                sender_idle_on = !sender_idle_on;
            if ($urandom_range(0, 63) == 0)
                receiver_idle_on = !receiver_idle_on;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                build_pattern(pick_positions(), pick_shape());
                send_bytes(1'b0, pat_bytes, 1'b1);
                repeat ($urandom_range(1, 3)) begin
                    build_word();
                    send_bytes(1'b1, word_bytes, 1'b1);
                end
            end else if (r < 85) begin
                build_word();
                send_bytes(1'b1, word_bytes, 1'b1);
            end else if (r < 93) begin
                build_word();
                if (word_bytes.size() < 2)
                    word_bytes.push_back(rand_symbol());
                k = $urandom_range(1, word_bytes.size() - 1);
                for (i = 0; i < k; i++)
                    send_item(1'b1, word_bytes[i], 1'b0);
                build_pattern(pick_positions(), PAT_CLEAN);
                send_bytes(1'b0, pat_bytes, 1'b1);
                for (i = k; i < word_bytes.size(); i++)
                    send_item(1'b1, word_bytes[i], i == word_bytes.size() - 1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        sender_idle_on = 1'b0;
        hold_request   = HOLD_CYCLES;
        for (i = 0; i < 30; i++) begin
            build_pattern(1, PAT_CLEAN);
            send_bytes(1'b0, pat_bytes, 1'b1);
            build_word();
            send_bytes(1'b1, word_bytes, 1'b1);
        end
        sender_idle_on = 1'b1;
    endtask

    task automatic finish_run();
        quiesce();
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    endtask

    // result side: per-word stall, or one long hold when asked
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (rst_done);
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end else begin
                gap = receiver_idle_on ? $urandom_range(0, 17) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        verdict_t seen;
        verdict_t want;
        if (rst_done && m_tvalid && m_tready) begin
            seen.kind    = m_tuser[0];
            seen.matched = m_tdata[0];
            seen.status  = status_t'(m_tdata[2:1]);
            seen.total   = m_tdata[7:3];
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d matched=%0d status=%0d total=%0d",
                             seen.kind, seen.matched, seen.status, seen.total);
            end else begin
                want = expected_verdicts.pop_front();
                if (seen.kind !== want.kind || seen.matched !== want.matched ||
                    seen.status !== want.status || seen.total !== want.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected kind=%0d matched=%0d status=%0d ",
                                  "total=%0d, got kind=%0d matched=%0d status=%0d total=%0d"},
                                 want.kind, want.matched, want.status, want.total,
                                 seen.kind, seen.matched, seen.status, seen.total);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (rst_done) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'h00;
        s_tuser          = 1'b0;
        s_tlast          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        mismatches       = 0;
        sent_items       = 0;
        quiet_cycles     = 0;
        hold_request     = 0;
        rst_done         = 1'b0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        clear_model();
        repeat (8) @(negedge aclk);
        aresetn  <= 1'b1;
        rst_done = 1'b1;

        test_unpatterned_word();
        test_bad_patterns();
        test_unclosed_sets();
        test_overflow();
        test_interleave();

        set_suffix_mode(1'b1);
        test_random_traffic(350);

        set_suffix_mode(1'b0);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        test_random_traffic(300);
        test_backpressure();

        set_suffix_mode(1'b1);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        test_random_traffic(400);

        set_suffix_mode(1'b0);
        test_random_traffic(400);

        finish_run();
    end

endmodule
